[hw/rtl/second_order_tracking_filter_unit_macros.svh]
// Assertion macros for the second-order tracking filter unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef SECOND_ORDER_TRACKING_FILTER_UNIT_MACROS_SVH
`define SECOND_ORDER_TRACKING_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SOTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SOTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sotf_pkg.sv]
// Shared types and constants of the second-order tracking filter unit.
// No dependencies; used by sotf_cfg, sotf_mul and the top level.
package sotf_pkg;

  localparam int SIGNAL_WIDTH = 32;
  localparam int STATE_WIDTH  = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int MUL_B_W    = 48;

  localparam int STIFFNESS_W = 48;
  localparam int DAMPING_W   = 32;
  localparam int TIME_STEP_W = 32;
  localparam int GAIN_W      = 32;
  localparam int VEL_LIM_W   = 31;
  localparam int ACC_LIM_W   = 39;
  localparam int START_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE    = 3'd6;

  localparam logic [STIFFNESS_W-1:0]   STIFFNESS_RST = 48'd6553600;
  localparam logic [DAMPING_W-1:0]     DAMPING_RST   = 32'd65536;
  localparam logic [TIME_STEP_W-1:0]   TIME_STEP_RST = 32'd4294967;
  localparam logic [GAIN_W-1:0]        GAIN_RST      = 32'd0;
  localparam logic [VEL_LIM_W-1:0]     VEL_LIM_RST   = 31'd0;
  localparam logic [ACC_LIM_W-1:0]     ACC_LIM_RST   = 39'd0;
  localparam logic signed [START_W-1:0] START_VALUE_RST = 32'sd0;

  // 0.95 in Q0.32
  localparam logic [31:0] DECAY_Q32 = 32'd4080218931;

  typedef struct packed {
    logic [STIFFNESS_W-1:0] stiffness;
    logic [DAMPING_W-1:0]   damping;
    logic [TIME_STEP_W-1:0] time_step;
    logic [GAIN_W-1:0]      integral_gain;
    logic [VEL_LIM_W-1:0]   velocity_limit;
    logic [ACC_LIM_W-1:0]   accel_limit;
  } cfg_t;

  typedef struct packed {
    logic go;
    logic wide;
    logic shift32;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[hw/rtl/sotf_cfg.sv]
// Configuration register file of the second-order tracking filter unit.
// Depends on sotf_pkg for register indexes, widths and reset values.
module sotf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr,
  input  logic [sotf_pkg::CFG_IDX_W-1:0]   idx,
  input  logic [sotf_pkg::CFG_DATA_W-1:0]  data,
  output sotf_pkg::cfg_t                   cfg
);

  sotf_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        sotf_pkg::REG_STIFFNESS:      cfg_nxt.stiffness = data[sotf_pkg::STIFFNESS_W-1:0];
        sotf_pkg::REG_DAMPING:        cfg_nxt.damping = data[sotf_pkg::DAMPING_W-1:0];
        sotf_pkg::REG_TIME_STEP:      cfg_nxt.time_step = data[sotf_pkg::TIME_STEP_W-1:0];
        sotf_pkg::REG_INTEGRAL_GAIN:  cfg_nxt.integral_gain = data[sotf_pkg::GAIN_W-1:0];
        sotf_pkg::REG_VELOCITY_LIMIT: cfg_nxt.velocity_limit = data[sotf_pkg::VEL_LIM_W-1:0];
        sotf_pkg::REG_ACCEL_LIMIT:    cfg_nxt.accel_limit = data[sotf_pkg::ACC_LIM_W-1:0];
        // start value writes are dropped: the level is loaded on reset from
        // START_VALUE_RST, so the level always restarts from its reset value
        sotf_pkg::REG_START_VALUE:    cfg_nxt = cfg_r;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness      <= sotf_pkg::STIFFNESS_RST;
      cfg_r.damping        <= sotf_pkg::DAMPING_RST;
      cfg_r.time_step      <= sotf_pkg::TIME_STEP_RST;
      cfg_r.integral_gain  <= sotf_pkg::GAIN_RST;
      cfg_r.velocity_limit <= sotf_pkg::VEL_LIM_RST;
      cfg_r.accel_limit    <= sotf_pkg::ACC_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/sotf_mul.sv]
// Shared iterative fixed-point multiplier: |a| * b in 32x32 partial products,
// then shift by 16 or 32, magnitude saturation and sign restore. Uses sotf_pkg.
module sotf_mul #(
  parameter int SW = sotf_pkg::STATE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sotf_pkg::mul_ctrl_t           ctrl,
  input  logic signed [SW-1:0]          a,
  input  logic [sotf_pkg::MUL_B_W-1:0]  b,
  output logic signed [SW-1:0]          res,
  output sotf_pkg::mul_stat_t           stat
);

  localparam int NA  = (SW + 31) / 32;
  localparam int MW  = NA * 32;
  localparam int AW  = MW + 64;
  localparam int IAW = (NA > 1) ? $clog2(NA) : 1;
  localparam logic [IAW-1:0] IA_LAST = IAW'(NA - 1);
  localparam logic signed [SW-1:0] ST_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] ST_LO = {1'b1, {(SW-1){1'b0}}};
  // magnitude clamp sits at 2^63-1 before the state clamp
  localparam logic signed [SW-1:0] NEG_SAT = (SW == 64) ? ST_LO + SW'(1) : ST_LO;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t             state_r, state_nxt;
  logic                done_r, done_nxt;
  logic                neg_r, neg_nxt;
  logic                wide_r, wide_nxt;
  logic                sh32_r, sh32_nxt;
  logic [MW-1:0]       m_r, m_nxt;
  logic [63:0]         b_r, b_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [IAW-1:0]      ia_r, ia_nxt;
  logic                ib_r, ib_nxt;
  logic signed [SW-1:0] res_r, res_nxt;

  logic [SW-1:0]  a_abs;
  logic [31:0]    m_chunk;
  logic [31:0]    b_chunk;
  logic [63:0]    pp;
  logic [IAW:0]   off;
  logic [AW-1:0]  q;
  logic [SW-1:0]  mag;
  logic           over;

  assign a_abs   = a[SW-1] ? (~a + SW'(1)) : a;
  assign m_chunk = m_r[{ia_r, 5'b0} +: 32];
  assign b_chunk = b_r[{ib_r, 5'b0} +: 32];
  assign pp      = m_chunk * b_chunk;
  assign off     = {1'b0, ia_r} + {{IAW{1'b0}}, ib_r};
  assign q       = sh32_r ? (acc_r >> 32) : (acc_r >> 16);
  assign over    = |q[AW-1:SW-1];
  assign mag     = q[SW-1:0];

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    wide_nxt  = wide_r;
    sh32_nxt  = sh32_r;
    m_nxt     = m_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    res_nxt   = res_r;
    case (state_r)
      M_IDLE: begin
        if (ctrl.go) begin
          neg_nxt   = a[SW-1];
          wide_nxt  = ctrl.wide;
          sh32_nxt  = ctrl.shift32;
          m_nxt     = MW'(a_abs);
          b_nxt     = 64'(b);
          acc_nxt   = '0;
          ia_nxt    = '0;
          ib_nxt    = 1'b0;
          state_nxt = M_RUN;
        end
      end
      M_RUN: begin
        acc_nxt = acc_r + (AW'(pp) << {off, 5'b0});
        if (ia_r == IA_LAST) begin
          ia_nxt = '0;
          if (ib_r || !wide_r) begin
            state_nxt = M_FIN;
          end else begin
            ib_nxt = 1'b1;
          end
        end else begin
          ia_nxt = ia_r + IAW'(1);
        end
      end
      M_FIN: begin
        if (!neg_r) begin
          res_nxt = over ? ST_HI : mag;
        end else begin
          res_nxt = over ? NEG_SAT : (~mag + SW'(1));
        end
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      neg_r   <= neg_nxt;
      wide_r  <= wide_nxt;
      sh32_r  <= sh32_nxt;
      m_r     <= m_nxt;
      b_r     <= b_nxt;
      acc_r   <= acc_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res       = res_r;
  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;

endmodule

[hw/rtl/second_order_tracking_filter_unit.sv]
// Top level of the second-order tracking filter unit: sequencer, state and
// saturating adder. Depends on sotf_pkg, sotf_cfg, sotf_mul and the macro header.
//
// Usage:
//   in_*  : one sample per transaction, in_tdata[SIGNAL_WIDTH-1:0] signed Q.16.
//   out_* : one result per sample: filtered value, rate, two clip flags.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Sequencing: a sample passes six times through the one shared 32x32
//   multiplier, two to four partial products each at STATE_WIDTH 48, plus
//   the saturating add, clip and sequencing steps; the next sample is
//   accepted only once the sequencer has returned to idle.
// in_tready is high only while the sequencer is idle.
// The result sits in an output register: a new sample is accepted while it
//   waits; if the receiver stalls, the next result waits in the last step
//   until the register frees up.
// Reset (rst_n low, synchronous) restores register reset values, clears
//   velocity and correction, loads the level from the start value reset
//   value and drops out_tvalid.
`include "second_order_tracking_filter_unit_macros.svh"

module second_order_tracking_filter_unit #(
  parameter int SIGNAL_WIDTH = sotf_pkg::SIGNAL_WIDTH,
  parameter int STATE_WIDTH  = sotf_pkg::STATE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // fields from bit 0: sample
  input  logic [((SIGNAL_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // fields from bit 0: filtered, rate, accel_clipped, rate_clipped
  output logic [((2*SIGNAL_WIDTH+2+7)/8)*8-1:0] out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sotf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sotf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SIG   = SIGNAL_WIDTH;
  localparam int SW    = STATE_WIDTH;
  localparam int OUT_W = ((2*SIG+2+7)/8)*8;
  localparam int MX0   = (SW > SIG) ? SW : SIG;
  localparam int GW    = ((MX0 > 40) ? MX0 : 40) + 2;

  localparam logic signed [SW-1:0]  ST_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  ST_LO = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SIG-1:0] SG_HI = {1'b0, {(SIG-1){1'b1}}};
  localparam logic signed [SIG-1:0] SG_LO = {1'b1, {(SIG-1){1'b0}}};
  localparam logic signed [GW-1:0]  ST_HI_G = GW'(ST_HI);
  localparam logic signed [GW-1:0]  ST_LO_G = GW'(ST_LO);
  localparam logic signed [GW-1:0]  SG_HI_G = GW'(SG_HI);
  localparam logic signed [GW-1:0]  SG_LO_G = GW'(SG_LO);

  function automatic logic signed [SW-1:0] sat_st(logic signed [GW-1:0] v);
    if (v > ST_HI_G) return ST_HI;
    else if (v < ST_LO_G) return ST_LO;
    else return v[SW-1:0];
  endfunction

  function automatic logic signed [SIG-1:0] sat_sig(logic signed [GW-1:0] v);
    if (v > SG_HI_G) return SG_HI;
    else if (v < SG_LO_G) return SG_LO;
    else return v[SIG-1:0];
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_GO1, S_WT1, S_GO2, S_WT2, S_CLA, S_GO3, S_WT3, S_CLV,
    S_GO4, S_WT4, S_LVL, S_ERR2, S_GO5, S_WT5, S_GO6, S_WT6, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;
  logic signed [SW-1:0] level_r, level_nxt;
  logic signed [SW-1:0] speed_r, speed_nxt;
  logic signed [SW-1:0] corr_r, corr_nxt;
  logic signed [SW-1:0] x_r, x_nxt;
  logic signed [SW-1:0] e_r, e_nxt;
  logic signed [SW-1:0] p_r, p_nxt;
  logic signed [SW-1:0] a_r, a_nxt;
  logic                 afire_r, afire_nxt;
  logic                 vfire_r, vfire_nxt;

  sotf_pkg::cfg_t       cfg;
  sotf_pkg::mul_ctrl_t  mul_ctrl;
  sotf_pkg::mul_stat_t  mul_stat;
  logic signed [SW-1:0] mul_a;
  logic [sotf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [SW-1:0] mul_res;

  logic signed [GW-1:0] alim_g;
  logic signed [GW-1:0] vlim_g;

  logic                 mul_wait;
  logic                 out_load;
  logic                 alim_on;

  assign cfg_ready = 1'b1;

  sotf_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cfg_valid && cfg_ready),
    .idx   (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  sotf_mul #(.SW(SW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mul_ctrl),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  assign alim_g = GW'(signed'({1'b0, cfg.accel_limit}));
  assign vlim_g = GW'(signed'({1'b0, cfg.velocity_limit}));

  always_comb begin
    mul_ctrl.go      = 1'b1;
    mul_ctrl.wide    = 1'b0;
    mul_ctrl.shift32 = 1'b1;
    case (state_r)
      S_GO1: begin
        mul_ctrl.wide    = 1'b1;
        mul_ctrl.shift32 = 1'b0;
        mul_a = e_r;
        mul_b = cfg.stiffness;
      end
      S_GO2: begin
        mul_ctrl.shift32 = 1'b0;
        mul_a = speed_r;
        mul_b = sotf_pkg::MUL_B_W'(cfg.damping);
      end
      S_GO3: begin
        mul_a = a_r;
        mul_b = sotf_pkg::MUL_B_W'(cfg.time_step);
      end
      S_GO4: begin
        mul_a = speed_r;
        mul_b = sotf_pkg::MUL_B_W'(cfg.time_step);
      end
      S_GO5: begin
        mul_a = e_r;
        mul_b = sotf_pkg::MUL_B_W'(cfg.integral_gain);
      end
      S_GO6: begin
        mul_a = corr_r;
        mul_b = sotf_pkg::MUL_B_W'(sotf_pkg::DECAY_Q32);
      end
      default: begin
        mul_ctrl.go = 1'b0;
        mul_a = e_r;
        mul_b = cfg.stiffness;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    level_nxt      = level_r;
    speed_nxt      = speed_r;
    corr_nxt       = corr_r;
    x_nxt          = x_r;
    e_nxt          = e_r;
    p_nxt          = p_r;
    a_nxt          = a_r;
    afire_nxt      = afire_r;
    vfire_nxt      = vfire_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = sat_st(GW'(signed'(in_tdata[SIG-1:0])));
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        e_nxt     = sat_st(GW'(x_r) - GW'(level_r));
        state_nxt = S_GO1;
      end
      S_GO1: state_nxt = S_WT1;
      S_WT1: begin
        if (mul_stat.done) begin
          p_nxt     = mul_res;
          state_nxt = S_GO2;
        end
      end
      S_GO2: state_nxt = S_WT2;
      S_WT2: begin
        if (mul_stat.done) begin
          a_nxt     = sat_st(GW'(p_r) - GW'(mul_res));
          state_nxt = S_CLA;
        end
      end
      S_CLA: begin
        afire_nxt = 1'b0;
        if (cfg.accel_limit != '0) begin
          if (GW'(a_r) > alim_g) begin
            a_nxt     = sat_st(alim_g);
            afire_nxt = 1'b1;
          end else if (GW'(a_r) < -alim_g) begin
            a_nxt     = sat_st(-alim_g);
            afire_nxt = 1'b1;
          end
        end
        state_nxt = S_GO3;
      end
      S_GO3: state_nxt = S_WT3;
      S_WT3: begin
        if (mul_stat.done) begin
          speed_nxt = sat_st(GW'(speed_r) + GW'(mul_res));
          state_nxt = S_CLV;
        end
      end
      S_CLV: begin
        vfire_nxt = 1'b0;
        if (cfg.velocity_limit != '0) begin
          if (GW'(speed_r) > vlim_g) begin
            speed_nxt = sat_st(vlim_g);
            vfire_nxt = 1'b1;
          end else if (GW'(speed_r) < -vlim_g) begin
            speed_nxt = sat_st(-vlim_g);
            vfire_nxt = 1'b1;
          end
        end
        state_nxt = S_GO4;
      end
      S_GO4: state_nxt = S_WT4;
      S_WT4: begin
        if (mul_stat.done) begin
          p_nxt     = sat_st(GW'(mul_res) + GW'(corr_r));
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        level_nxt = sat_st(GW'(level_r) + GW'(p_r));
        state_nxt = S_ERR2;
      end
      S_ERR2: begin
        e_nxt     = sat_st(GW'(x_r) - GW'(level_r));
        state_nxt = S_GO5;
      end
      S_GO5: state_nxt = S_WT5;
      S_WT5: begin
        if (mul_stat.done) begin
          corr_nxt  = sat_st(GW'(corr_r) + GW'(mul_res));
          state_nxt = S_GO6;
        end
      end
      S_GO6: state_nxt = S_WT6;
      S_WT6: begin
        if (mul_stat.done) begin
          corr_nxt  = mul_res;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = OUT_W'({vfire_r, afire_r,
                                   sat_sig(GW'(speed_r)), sat_sig(GW'(level_r))});
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      level_r      <= sat_st(GW'(sotf_pkg::START_VALUE_RST));
      speed_r      <= '0;
      corr_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_data_r   <= out_data_nxt;
      level_r      <= level_nxt;
      speed_r      <= speed_nxt;
      corr_r       <= corr_nxt;
      x_r          <= x_nxt;
      e_r          <= e_nxt;
      p_r          <= p_nxt;
      a_r          <= a_nxt;
      afire_r      <= afire_nxt;
      vfire_r      <= vfire_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign mul_wait = (state_r inside {S_WT1, S_WT2, S_WT3, S_WT4, S_WT5, S_WT6});
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  assign alim_on  = (cfg.accel_limit != '0);

  `SOTF_ASSERT_NOW(a_idle_mul_free, clk, rst_n, in_tready, !mul_stat.busy, "multiplier busy")
  `SOTF_ASSERT_NOW(a_done_in_wait, clk, rst_n, mul_stat.done, mul_wait, "result outside wait")
  `SOTF_ASSERT_NEXT(a_out_load, clk, rst_n, out_load, out_tvalid, "result not presented")
  `SOTF_ASSERT_NOW(a_afire_lim, clk, rst_n, (state_r == S_GO3 && afire_r), alim_on, "clip, no limit")

endmodule
